// File: hw/rtl/csvlcs_pkg.sv
// shared types and constants of the csv line cell splitter
package csvlcs_pkg;

    // configuration register indexes (word address bit 2)
    localparam logic REG_DELIM = 1'b0;
    localparam logic REG_QUOTE = 1'b1;

    // reset values of the configuration registers
    localparam logic [7:0] DELIM_RESET = 8'd44;
    localparam logic [7:0] QUOTE_RESET = 8'd34;

    // parser mode; the fourth code behaves as normal
    typedef enum logic [1:0] {
        MODE_NORMAL     = 2'd0,
        MODE_QUOTED     = 2'd1,
        MODE_QUOTE_SEEN = 2'd2
    } mode_t;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_HELD,
        S_RD,
        S_PEND,
        S_POST,
        S_BYTE,
        S_LINE
    } state_t;

    // kind of result loaded into the output register
    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_HELD,
        EMIT_PEND,
        EMIT_BYTE,
        EMIT_CELL,
        EMIT_LINE
    } emit_t;

    // commands from controller to datapath
    typedef struct packed {
        logic  accept;
        logic  store;
        logic  set_held;
        logic  rd;
        logic  ov;
        emit_t emit;
    } ctrl_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic out_free;
        logic flush;
        logic ov;
        logic store;
        logic set_held;
        logic put_byte;
        logic cell_close;
        logic last;
        logic held;
        logic cnt_nz;
        logic idx_last;
    } dp_status_t;

endpackage

// File: hw/rtl/csvlcs_ctrl.sv
// controller state machine sequencing the results of one item
module csvlcs_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  csvlcs_pkg::dp_status_t st,
    output csvlcs_pkg::ctrl_cmd_t  cmd
);
    import csvlcs_pkg::*;

    state_t state_reg, state_next;
    logic   plan_ov_reg, plan_ov_next;
    logic   plan_store_reg, plan_store_next;
    logic   plan_held_reg, plan_held_next;
    logic   plan_byte_reg, plan_byte_next;
    logic   plan_last_reg, plan_last_next;

    // state and plan registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            plan_ov_reg    <= 1'b0;
            plan_store_reg <= 1'b0;
            plan_held_reg  <= 1'b0;
            plan_byte_reg  <= 1'b0;
            plan_last_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            plan_ov_reg    <= plan_ov_next;
            plan_store_reg <= plan_store_next;
            plan_held_reg  <= plan_held_next;
            plan_byte_reg  <= plan_byte_next;
            plan_last_reg  <= plan_last_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next      = state_reg;
        plan_ov_next    = plan_ov_reg;
        plan_store_next = plan_store_reg;
        plan_held_next  = plan_held_reg;
        plan_byte_next  = plan_byte_reg;
        plan_last_next  = plan_last_reg;
        s_ready         = 1'b0;
        cmd             = '{accept: 1'b0, store: 1'b0, set_held: 1'b0, rd: 1'b0,
                            ov: plan_ov_reg, emit: EMIT_NONE};
        unique case (state_reg)
            S_IDLE: begin
                s_ready = st.out_free;
                if (s_valid && st.out_free) begin
                    cmd.accept      = 1'b1;
                    plan_ov_next    = st.ov;
                    plan_store_next = st.store;
                    plan_held_next  = st.set_held;
                    plan_byte_next  = st.put_byte;
                    plan_last_next  = st.last;
                    if (st.flush) begin
                        // tail must drain before this item's own action
                        state_next = st.held ? S_HELD : S_RD;
                    end else begin
                        cmd.store    = st.store;
                        cmd.set_held = st.set_held;
                        priority if (st.put_byte) begin
                            cmd.emit = EMIT_BYTE;
                        end else if (st.cell_close) begin
                            cmd.emit = EMIT_CELL;
                        end else if (st.last) begin
                            cmd.emit = EMIT_LINE;
                        end else begin
                            cmd.emit = EMIT_NONE;
                        end
                        state_next = (st.last && (st.put_byte || st.cell_close)) ?
                                     S_LINE : S_IDLE;
                    end
                end
            end
            S_HELD: begin
                if (st.out_free) begin
                    cmd.emit   = EMIT_HELD;
                    state_next = st.cnt_nz ? S_RD : S_POST;
                end
            end
            S_RD: begin
                cmd.rd     = 1'b1;
                state_next = S_PEND;
            end
            S_PEND: begin
                if (st.out_free) begin
                    cmd.emit   = EMIT_PEND;
                    state_next = st.idx_last ? S_POST : S_RD;
                end
            end
            S_POST: begin
                cmd.store    = plan_store_reg;
                cmd.set_held = plan_held_reg;
                state_next   = plan_byte_reg ? S_BYTE : (plan_last_reg ? S_LINE : S_IDLE);
            end
            S_BYTE: begin
                if (st.out_free) begin
                    cmd.emit   = EMIT_BYTE;
                    state_next = plan_last_reg ? S_LINE : S_IDLE;
                end
            end
            S_LINE: begin
                if (st.out_free) begin
                    cmd.emit   = EMIT_LINE;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/csvlcs_dp.sv
// datapath: configuration, cell state, whitespace buffer and output register
module csvlcs_dp #(
    parameter int PEND_DEPTH = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    input  logic [7:0]             s_in_byte,
    input  logic                   s_line_last,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [7:0]             m_out_byte,
    output logic                   m_has_byte,
    output logic                   m_cell_end,
    output logic                   m_line_end,
    output logic                   m_overflow,
    input  csvlcs_pkg::ctrl_cmd_t  cmd,
    output csvlcs_pkg::dp_status_t st
);
    import csvlcs_pkg::*;

    localparam int CW = $clog2(PEND_DEPTH + 1);
    localparam int AW = (PEND_DEPTH > 1) ? $clog2(PEND_DEPTH) : 1;

    function automatic logic is_space(input logic [7:0] c);
        is_space = (c >= 8'h09 && c <= 8'h0D) || c == 8'h20 || c == 8'h85 || c == 8'hA0;
    endfunction

    logic [7:0]    delim_reg, quote_reg;
    mode_t         mode_reg, mode_next;
    logic          started_reg, started_next;
    logic          strip_reg, strip_next;
    logic          held_reg, held_next;
    logic          nonempty_reg, nonempty_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] idx_inc;
    logic [7:0]    c_reg;
    logic [7:0]    rdata_reg;
    logic [7:0]    pend_mem [PEND_DEPTH];

    logic          m_valid_reg;
    logic [7:0]    out_byte_reg;
    logic          has_byte_reg, cell_end_reg, line_end_reg, overflow_reg;

    logic          is_q, is_d, sp;
    logic          n_normal, delim, add, first, later;
    mode_t         ev_mode;
    logic          ev_started, ev_strip, ev_nonempty;
    logic          out_free;

    // configuration port
    assign pready = 1'b1;
    assign prdata = {24'd0, (paddr[2] == REG_QUOTE) ? quote_reg : delim_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delim_reg <= DELIM_RESET;
            quote_reg <= QUOTE_RESET;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_QUOTE) begin
                quote_reg <= pwdata[7:0];
            end else begin
                delim_reg <= pwdata[7:0];
            end
        end
    end

    assign idx_inc  = idx_reg + CW'(1);
    assign out_free = !m_valid_reg || m_ready;

    // decode of the offered item against the current cell state
    always_comb begin
        is_q     = s_in_byte == quote_reg;
        is_d     = s_in_byte == delim_reg;
        sp       = is_space(s_in_byte);
        n_normal = 1'b0;
        add      = 1'b0;
        ev_mode  = MODE_NORMAL;
        unique case (mode_reg)
            MODE_QUOTE_SEEN: begin
                n_normal = !is_q;
                ev_mode  = is_q ? MODE_QUOTED : MODE_NORMAL;
            end
            MODE_QUOTED: begin
                add     = 1'b1;
                ev_mode = is_q ? MODE_QUOTE_SEEN : MODE_QUOTED;
            end
            default: begin
                n_normal = 1'b1;
            end
        endcase
        delim = n_normal && is_d;
        if (n_normal && !is_d) begin
            add = 1'b1;
            if (is_q) begin
                ev_mode = MODE_QUOTED;
            end
        end
        first = add && !sp && !started_reg;
        later = add && !sp && started_reg;

        ev_started  = delim ? 1'b0 : (first ? 1'b1 : started_reg);
        ev_strip    = delim ? 1'b0 : ((first && is_q) ? 1'b1 : strip_reg);
        ev_nonempty = add ? 1'b1 : (delim ? 1'b0 : nonempty_reg);

        st.store      = add && sp && started_reg;
        st.ov         = st.store && (count_reg == CW'(PEND_DEPTH));
        st.flush      = st.ov || (later && (held_reg || count_reg != '0));
        st.put_byte   = (first && !is_q) || (later && !(strip_reg && is_q));
        st.set_held   = later && strip_reg && is_q;
        st.cell_close = delim;
        st.last       = s_line_last;
        st.out_free   = out_free;
        st.held       = held_reg;
        st.cnt_nz     = count_reg != '0;
        st.idx_last   = idx_inc == count_reg;
    end

    // cell state next values
    always_comb begin
        mode_next     = mode_reg;
        started_next  = started_reg;
        strip_next    = strip_reg;
        held_next     = held_reg;
        nonempty_next = nonempty_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        if (cmd.accept) begin
            mode_next     = ev_mode;
            started_next  = ev_started;
            strip_next    = ev_strip;
            nonempty_next = ev_nonempty;
            if (delim) begin
                held_next  = 1'b0;
                count_next = '0;
            end
        end
        if (cmd.emit == EMIT_HELD) begin
            held_next = 1'b0;
        end
        if (cmd.emit == EMIT_PEND) begin
            if (st.idx_last) begin
                idx_next   = '0;
                count_next = '0;
            end else begin
                idx_next = idx_inc;
            end
        end
        if (cmd.store) begin
            count_next = count_reg + CW'(1);
        end
        if (cmd.set_held) begin
            held_next = 1'b1;
        end
        if (cmd.emit == EMIT_LINE) begin
            mode_next     = MODE_NORMAL;
            started_next  = 1'b0;
            strip_next    = 1'b0;
            held_next     = 1'b0;
            nonempty_next = 1'b0;
            count_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_NORMAL;
            started_reg  <= 1'b0;
            strip_reg    <= 1'b0;
            held_reg     <= 1'b0;
            nonempty_reg <= 1'b0;
            count_reg    <= '0;
            idx_reg      <= '0;
        end else begin
            mode_reg     <= mode_next;
            started_reg  <= started_next;
            strip_reg    <= strip_next;
            held_reg     <= held_next;
            nonempty_reg <= nonempty_next;
            count_reg    <= count_next;
            idx_reg      <= idx_next;
        end
    end

    // item byte capture
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            c_reg <= s_in_byte;
        end
    end

    // trailing whitespace buffer
    always_ff @(posedge aclk) begin
        if (cmd.store) begin
            pend_mem[count_reg[AW-1:0]] <= cmd.accept ? s_in_byte : c_reg;
        end
        if (cmd.rd) begin
            rdata_reg <= pend_mem[idx_reg[AW-1:0]];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit != EMIT_NONE) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.emit)
            EMIT_HELD: begin
                out_byte_reg <= quote_reg;
                has_byte_reg <= 1'b1;
                cell_end_reg <= 1'b0;
                line_end_reg <= 1'b0;
                overflow_reg <= cmd.ov;
            end
            EMIT_PEND: begin
                out_byte_reg <= rdata_reg;
                has_byte_reg <= 1'b1;
                cell_end_reg <= 1'b0;
                line_end_reg <= 1'b0;
                overflow_reg <= cmd.ov;
            end
            EMIT_BYTE: begin
                out_byte_reg <= cmd.accept ? s_in_byte : c_reg;
                has_byte_reg <= 1'b1;
                cell_end_reg <= 1'b0;
                line_end_reg <= 1'b0;
                overflow_reg <= 1'b0;
            end
            EMIT_CELL: begin
                out_byte_reg <= 8'd0;
                has_byte_reg <= 1'b0;
                cell_end_reg <= 1'b1;
                line_end_reg <= 1'b0;
                overflow_reg <= 1'b0;
            end
            EMIT_LINE: begin
                out_byte_reg <= 8'd0;
                has_byte_reg <= 1'b0;
                cell_end_reg <= cmd.accept ? ev_nonempty : nonempty_reg;
                line_end_reg <= 1'b1;
                overflow_reg <= 1'b0;
            end
            default: begin
            end
        endcase
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = out_byte_reg;
    assign m_has_byte = has_byte_reg;
    assign m_cell_end = cell_end_reg;
    assign m_line_end = line_end_reg;
    assign m_overflow = overflow_reg;

endmodule

// File: hw/rtl/csv_line_cell_splitter_unit.sv
// top level of the csv line cell splitter
// Splits a line of Latin-1 text into cells. Input channel (s_valid/s_ready)
// takes one byte per item with s_line_last on the final byte of the line.
// Result channel (m_valid/m_ready) gives content bytes, cell-end marks and a
// closing line-end mark, through a single output register.
// Delimiter and quote bytes are set over the APB port (0x0 and 0x4).
// Sequencing: an item whose results are at most one byte or mark, or that is
// only buffered, is applied at the edge that accepts it; a line-end after a
// byte or cell-end adds a line state. Draining the trailing whitespace buffer
// adds a held-quote state, a memory read then an output load per buffered
// byte, a post state to apply the item afterwards and a byte state when the
// item then gives a byte; this buffer sets the worst-case rate.
// When nothing drains, an item's first result is loaded into the output
// register at the edge that accepts it, so it can be taken in the next cycle.
// While the receiver stalls, the output register holds its result and no
// further item or result is taken.
// Reset (aresetn low, synchronous) restores comma and double quote, clears
// the parser state and empties the output register; buffer contents are
// don't-care.
module csv_line_cell_splitter_unit #(
    parameter int PEND_DEPTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_line_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_has_byte,
    output logic        m_cell_end,
    output logic        m_line_end,
    output logic        m_overflow
);
    import csvlcs_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t st;

    // sequencing
    csvlcs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    // datapath
    csvlcs_dp #(
        .PEND_DEPTH (PEND_DEPTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .s_in_byte   (s_in_byte),
        .s_line_last (s_line_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_has_byte  (m_has_byte),
        .m_cell_end  (m_cell_end),
        .m_line_end  (m_line_end),
        .m_overflow  (m_overflow),
        .cmd         (cmd),
        .st          (st)
    );

endmodule
